>>> rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps

package i2a_pkg;

    // Character store depth; a run longer than this loses its leading characters
    localparam int MAX_CHARS = 33;

    localparam int WORD_W   = 32;
    localparam int RADIX_W  = 5;
    localparam int REM_W    = RADIX_W - 1;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int ADDR_W   = $clog2(MAX_CHARS);
    localparam int KEPT_W   = $clog2(MAX_CHARS + 1);

    // Divider retires this many quotient bits per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = WORD_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [CHAR_W-1:0]  MINUS_GLYPH = 8'h2D;

    localparam int IN_TDATA_W  = ((WORD_W + RADIX_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CHAR_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_FETCH,
        ST_SHOW
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [WORD_W-1:0]    dividend;
        logic [RADIX_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [WORD_W-1:0]    quotient;
        logic [REM_W-1:0]     remainder;
    } t_div_stat;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [CHAR_W-1:0]    data;
    } t_buf_wr;

    typedef struct packed {
        logic                 re;
        logic [ADDR_W-1:0]    addr;
    } t_buf_rd;

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [REM_W-1:0] d);
        logic [CHAR_W-1:0] g;
        unique case (d)
            4'h0: g = 8'h30;
            4'h1: g = 8'h31;
            4'h2: g = 8'h32;
            4'h3: g = 8'h33;
            4'h4: g = 8'h34;
            4'h5: g = 8'h35;
            4'h6: g = 8'h36;
            4'h7: g = 8'h37;
            4'h8: g = 8'h38;
            4'h9: g = 8'h39;
            4'hA: g = 8'h41;
            4'hB: g = 8'h42;
            4'hC: g = 8'h43;
            4'hD: g = 8'h44;
            4'hE: g = 8'h45;
            4'hF: g = 8'h46;
            default: g = 8'h30;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/i2a_div.sv
`timescale 1ns / 1ps

// Shared divider: 32-bit word by a radix of up to 16, DIV_BITS quotient bits a cycle.
// Quotient bits shift into the bottom of the work register as dividend bits leave the top.
module i2a_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2a_pkg::t_div_req   i_req,
    output i2a_pkg::t_div_stat  o_stat
);
    import i2a_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [WORD_W-1:0]   r_work;
    logic [REM_W-1:0]    r_rem;
    logic [RADIX_W-1:0]  r_div;

    logic [REM_W-1:0]    step_rem;
    logic [DIV_BITS-1:0] step_q;

    always_comb begin
        logic [RADIX_W-1:0] trial;
        step_rem = r_rem;
        step_q   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {step_rem, r_work[WORD_W-1-i]};
            if (trial >= r_div) begin
                step_rem              = REM_W'(trial - r_div);
                step_q[DIV_BITS-1-i]  = 1'b1;
            end else begin
                step_rem = trial[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= {r_work[WORD_W-DIV_BITS-1:0], step_q};
            r_rem  <= step_rem;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_work;
    assign o_stat.remainder = r_rem;

endmodule

>>> rtl/core/i2a_buf.sv
`timescale 1ns / 1ps

// Character store, least significant digit at address 0; registered read.
module i2a_buf (
    input  logic                          i_clk,
    input  i2a_pkg::t_buf_wr              i_wr,
    input  i2a_pkg::t_buf_rd              i_rd,
    output logic [i2a_pkg::CHAR_W-1:0]    o_rd_data
);
    import i2a_pkg::*;

    logic [CHAR_W-1:0] r_mem [MAX_CHARS];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            o_rd_data <= r_mem[i_rd.addr];
        end
    end

endmodule

>>> rtl/core/integer_to_ascii_radix.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                       tuser / tlast
// s_axis    in         value[31:0], radix[36:32], pad to 40     tuser[0] = signed_mode
// m_axis    out        character[7:0], char_count[13:8], pad    tlast = last
//
// One transaction in at a time; s_axis tready is high only while idle.
// Each digit takes one pass of the shared divider (4 steps of 8 quotient bits plus handoff).
// Characters are read back from the store one by one; m_axis stalls hold the output.
// Synchronous active-low reset returns the sequencer to idle; the store is not cleared.
module integer_to_ascii_radix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [i2a_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // value, radix
    input  logic [0:0]                          i_s_axis_tuser,  // signed_mode
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [i2a_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,  // character, char_count
    output logic                                o_m_axis_tlast
);
    import i2a_pkg::*;

    t_state              r_state, n_state;
    logic [KEPT_W-1:0]   r_kept,  n_kept;
    logic [ADDR_W-1:0]   r_idx,   n_idx;
    logic                r_neg,   n_neg;
    logic [RADIX_W-1:0]  r_radix, n_radix;

    t_div_req            div_req;
    t_div_stat           div_stat;
    t_buf_wr             buf_wr;
    t_buf_rd             buf_rd;
    logic [CHAR_W-1:0]   rd_char;

    logic                in_fire;
    logic                out_fire;
    logic [WORD_W-1:0]   in_value;
    logic [RADIX_W-1:0]  in_radix;
    logic [RADIX_W-1:0]  radix_sat;
    logic                in_neg;
    logic [WORD_W-1:0]   in_mag;
    logic                room;
    logic [KEPT_W-1:0]   kept_fin;
    logic                is_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_SHOW);

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign in_value = i_s_axis_tdata[WORD_W-1:0];
    assign in_radix = i_s_axis_tdata[WORD_W+RADIX_W-1:WORD_W];
    assign in_neg   = i_s_axis_tuser[0] && in_value[WORD_W-1];
    assign in_mag   = in_neg ? (WORD_W'(0) - in_value) : in_value;
    assign room     = r_kept < KEPT_W'(MAX_CHARS);
    assign kept_fin = (r_neg && room) ? (r_kept + KEPT_W'(1)) : r_kept;
    assign is_last  = (r_idx == '0);

    always_comb begin
        priority if (in_radix < RADIX_MIN) begin
            radix_sat = RADIX_MIN;
        end else if (in_radix > RADIX_MAX) begin
            radix_sat = RADIX_MAX;
        end else begin
            radix_sat = in_radix;
        end
    end

    i2a_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    i2a_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd      (buf_rd),
        .o_rd_data (rd_char)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_fire) n_state = ST_DIV;
            ST_DIV:   if (div_stat.done && div_stat.quotient == '0) n_state = ST_SIGN;
            ST_SIGN:  n_state = ST_FETCH;
            ST_FETCH: n_state = ST_SHOW;
            ST_SHOW: begin
                if (out_fire) begin
                    n_state = is_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = div_stat.quotient;
        div_req.divisor  = r_radix;
        buf_wr.we        = 1'b0;
        buf_wr.addr      = r_kept[ADDR_W-1:0];
        buf_wr.data      = digit_glyph(div_stat.remainder);
        buf_rd.re        = 1'b0;
        buf_rd.addr      = r_idx;
        n_kept           = r_kept;
        n_idx            = r_idx;
        n_neg            = r_neg;
        n_radix          = r_radix;
        unique case (r_state)
            ST_IDLE: begin
                div_req.start    = in_fire;
                div_req.dividend = in_mag;
                div_req.divisor  = radix_sat;
                if (in_fire) begin
                    n_kept  = '0;
                    n_neg   = in_neg;
                    n_radix = radix_sat;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    // digits past the store depth are dropped, keeping the low ones
                    if (room) begin
                        buf_wr.we = 1'b1;
                        n_kept    = r_kept + KEPT_W'(1);
                    end
                    div_req.start = (div_stat.quotient != '0);
                end
            end
            ST_SIGN: begin
                buf_wr.data = MINUS_GLYPH;
                buf_wr.we   = r_neg && room;
                n_kept      = kept_fin;
                n_idx       = ADDR_W'(kept_fin - KEPT_W'(1));
            end
            ST_FETCH: begin
                buf_rd.re = 1'b1;
            end
            ST_SHOW: begin
                if (out_fire && !is_last) begin
                    n_idx = r_idx - ADDR_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kept  <= '0;
        end else begin
            r_state <= n_state;
            r_kept  <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_neg   <= n_neg;
        r_radix <= n_radix;
    end

    assign o_m_axis_tdata = {{(OUT_TDATA_W - CHAR_W - COUNT_W){1'b0}},
                             COUNT_W'(r_kept), rd_char};
    assign o_m_axis_tlast = is_last;

    // Input and output sides never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input accepted while a character is on offer");

    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept <= KEPT_W'(MAX_CHARS))
        else $error("character count beyond store depth");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> r_state == ST_DIV)
        else $error("divider finished outside the digit loop");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("not idle after the final character");

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_kept != '0)
        else $error("character offered from an empty run");

endmodule
